### rtl/dday_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dday_pkg
// Shared widths, date type, month table and stage enables for the day counter.
// ----------------------------------------------------------------------------
package dday_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;

    localparam int MAX_YEAR = 9999;

    // years-before-date count and day of year
    localparam int BASE_W = 23;
    localparam int DOY_W  = 9;

    // p/100 as (p>>2)*5243 >> 17, exact for p>>2 below 43690
    localparam int Q4_W        = YEAR_W - 2;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = Q4_W + RECIP_W;
    localparam int RECIP_SHIFT = 17;
    localparam int C100_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

    // days in the months before m of a common year
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        begin
            case (m)
                4'd1:    r = 9'd0;
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/date_difference_days_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// date_difference_days_top
// Gregorian day count from a start date to an end date, four-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one request (start and end date) per cycle when the output side is not
// stalled and returns the number of days between them. Throughput is one
// request per clock while the output is not stalled; the pipeline has four
// register stages: year arithmetic and reciprocal multiply for /100, then
// years-before count and day of year, then the two differences, then the
// output register. Leap years are counted in closed form, so no year walk.
// Error is raised for a year of 0 or above 9999, a month outside 1..12, a
// day of 0, an end date before the start, or an overlong day that pushes the
// start past the end; day_count is then 0. Days are not checked against the
// month length, so February 31 runs on into March. Backpressure stalls a
// stage only when it and all stages ahead are full; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module date_difference_days_top (
    input  logic        clk,
    input  logic        rst_n,
    // start_year[13:0], start_month[17:14], start_day[22:18],
    // end_year[36:23], end_month[40:37], end_day[45:41], zero pad[47:46]
    input  logic [47:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // day_count[21:0], zero pad[23:22]
    output logic [23:0] m_tdata,
    // error[0]
    output logic        m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import dday_pkg::*;

    localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
    localparam int DIFF_W  = BASE_W + 1;
    localparam int DD_W    = DOY_W + 1;
    localparam logic [COUNT_W-1:0] MAX_DAYS = 22'd3652059;

    // ---- input unpack ------------------------------------------------------
    date_t first_date;
    date_t end_date;

    always_comb
    begin
        first_date.year  = s_tdata[YEAR_W-1:0];
        first_date.month = s_tdata[YEAR_W+MONTH_W-1:YEAR_W];
        first_date.day   = s_tdata[DATE_W-1:YEAR_W+MONTH_W];
        end_date.year    = s_tdata[DATE_W+YEAR_W-1:DATE_W];
        end_date.month   = s_tdata[DATE_W+YEAR_W+MONTH_W-1:DATE_W+YEAR_W];
        end_date.day     = s_tdata[2*DATE_W-1:DATE_W+YEAR_W+MONTH_W];
    end

    // ---- flow control: each stage loads when empty or when it moves on -----
    logic v1_reg, v2_reg, v3_reg, out_v_reg;
    logic rdy1, rdy2, rdy3, rdy_out;
    stage_en_t en;

    always_comb
    begin
        rdy_out = !out_v_reg || m_tready;
        rdy3    = !v3_reg || rdy_out;
        rdy2    = !v2_reg || rdy3;
        rdy1    = !v1_reg || rdy2;
        en.s1   = rdy1;
        en.s2   = rdy2;
    end

    assign s_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_tvalid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy_out)
                out_v_reg <= v3_reg;
        end
    end

    // ---- stage 1/2: validity travels alongside the serial day units --------
    logic bad_next;
    logic err1_reg, err2_reg, err3_reg;

    dday_check u_check (
        .first_date (first_date),
        .end_date   (end_date),
        .bad        (bad_next)
    );

    logic [BASE_W-1:0] start_base, end_base;
    logic [DOY_W-1:0]  start_doy,  end_doy;

    dday_serial u_start (
        .clk         (clk),
        .en          (en),
        .date        (first_date),
        .year_base   (start_base),
        .day_of_year (start_doy)
    );

    dday_serial u_end (
        .clk         (clk),
        .en          (en),
        .date        (end_date),
        .year_base   (end_base),
        .day_of_year (end_doy)
    );

    // ---- stage 3: year and day-of-year differences -------------------------
    logic [BASE_W-1:0] dy_reg;
    logic [DD_W-1:0]   dd_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
            err1_reg <= bad_next;
        if (rdy2)
            err2_reg <= err1_reg;
        if (rdy3)
        begin
            err3_reg <= err2_reg;
            dy_reg   <= end_base - start_base;
            dd_reg   <= DD_W'(end_doy) - DD_W'(start_doy);
        end
    end

    // ---- stage 4: sum, sign test, output register --------------------------
    logic [DIFF_W-1:0]  diff;
    logic               err_final;
    logic [COUNT_W-1:0] count_reg;
    logic               err_out_reg;

    always_comb
    begin
        diff = {1'b0, dy_reg} + {{(DIFF_W-DD_W){dd_reg[DD_W-1]}}, dd_reg};
        // negative total only from an overlong start day in the same year
        err_final = err3_reg || diff[DIFF_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            err_out_reg <= err_final;
            count_reg   <= err_final ? '0 : diff[COUNT_W-1:0];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {2'b00, count_reg};
    assign m_tuser  = err_out_reg;

`ifndef SYNTH
    // an error result always carries a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[COUNT_W-1:0] == '0)
        else $error("error result with non-zero day count");

    // a good result never exceeds the span of the supported years
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[COUNT_W-1:0] <= MAX_DAYS)
        else $error("day count beyond supported range");

    // input side only blocks when every stage holds a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> v1_reg && v2_reg && v3_reg && out_v_reg)
        else $error("input stalled with a pipeline bubble");

    // a stalled output stage keeps the stage behind it frozen
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && v3_reg |=> v3_reg && $stable(dy_reg))
        else $error("stage 3 moved while output stalled");
`endif

endmodule
`default_nettype wire

### rtl/dday_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dday_check
// Range checks on both dates and end-before-start test.
// ----------------------------------------------------------------------------
module dday_check (
    input  dday_pkg::date_t first_date,
    input  dday_pkg::date_t end_date,
    output logic            bad
);
    import dday_pkg::*;

    logic start_ok;
    logic end_ok;
    logic end_first;

    always_comb
    begin
        start_ok = (first_date.year != '0)
                && (first_date.year <= YEAR_W'(MAX_YEAR))
                && (first_date.month >= MONTH_JAN)
                && (first_date.month <= MONTH_DEC)
                && (first_date.day != '0);
        end_ok   = (end_date.year != '0)
                && (end_date.year <= YEAR_W'(MAX_YEAR))
                && (end_date.month >= MONTH_JAN)
                && (end_date.month <= MONTH_DEC)
                && (end_date.day != '0);
        // year, month, day compared as one word
        end_first = end_date < first_date;
        bad = !start_ok || !end_ok || end_first;
    end

endmodule
`default_nettype wire

### rtl/dday_serial.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dday_serial
// Two-stage serial day split: days in all earlier years, and day of year.
// ----------------------------------------------------------------------------
module dday_serial (
    input  logic                           clk,
    input  dday_pkg::stage_en_t            en,
    input  dday_pkg::date_t                date,
    output logic [dday_pkg::BASE_W-1:0]    year_base,
    output logic [dday_pkg::DOY_W-1:0]     day_of_year
);
    import dday_pkg::*;

    // stage 1
    logic [YEAR_W-1:0]  p;
    logic [BASE_W-1:0]  p365_next, p365_reg;
    logic [Q4_W-1:0]    q4_next, q4_reg;
    logic [PROD_W-1:0]  prod_next, prod_reg;
    logic [1:0]         ylow_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;

    // stage 2
    logic [C100_W-1:0]  c100;
    logic [Q4_W-1:0]    c25;
    logic [Q4_W-1:0]    rem;
    logic               century;
    logic               leap;
    logic [BASE_W-1:0]  year_base_next, year_base_reg;
    logic [DOY_W-1:0]   doy_next, doy_reg;

    always_comb
    begin
        p = date.year - YEAR_W'(1);
        // p * 365 as shift-add
        p365_next = BASE_W'({p, 8'b0}) + BASE_W'({p, 6'b0}) + BASE_W'({p, 5'b0})
                  + BASE_W'({p, 3'b0}) + BASE_W'({p, 2'b0}) + BASE_W'(p);
        q4_next   = p[YEAR_W-1:2];
        prod_next = PROD_W'(q4_next) * PROD_W'(RECIP_25);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            p365_reg  <= p365_next;
            q4_reg    <= q4_next;
            prod_reg  <= prod_next;
            ylow_reg  <= date.year[1:0];
            month_reg <= date.month;
            day_reg   <= date.day;
        end
    end

    always_comb
    begin
        c100 = prod_reg[PROD_W-1:RECIP_SHIFT];
        c25  = Q4_W'({c100, 4'b0}) + Q4_W'({c100, 3'b0}) + Q4_W'(c100);
        rem  = q4_reg - c25;
        // year is a century when (p>>2) mod 25 is 24 and year mod 4 is 0
        century = (rem == Q4_W'(24));
        leap    = (ylow_reg == 2'd0) && (!century || (c100[1:0] == 2'd3));
        year_base_next = p365_reg + BASE_W'(q4_reg) - BASE_W'(c100)
                       + BASE_W'(c100[C100_W-1:2]);
        doy_next = days_before_month(month_reg)
                 + DOY_W'(leap && (month_reg > MONTH_FEB))
                 + DOY_W'(day_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            year_base_reg <= year_base_next;
            doy_reg       <= doy_next;
        end
    end

    assign year_base   = year_base_reg;
    assign day_of_year = doy_reg;

endmodule
`default_nettype wire
